// ===== rtl/pcl_pkg.sv =====
// Shared constants, codes and types for the positional character list.
package pcl_pkg;

  // Number of byte cells in the chain.
  localparam int CAPACITY = 32;

  // Field widths fixed by the interface.
  localparam int POS_W  = 6;
  localparam int CHAR_W = 8;

  // Cell index, fill count and a compare width that holds both count+1 and a position.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  k;
    logic [CHAR_W-1:0] din;
  } cell_ctl_t;

endpackage

// ===== rtl/pcl_cell.sv =====
// One storage cell of the chain: holds a byte and shifts with its neighbors.
module pcl_cell (
  input  logic                         clk,
  input  pcl_pkg::cell_ctl_t           ctl,
  input  logic [pcl_pkg::IDX_W-1:0]    my_idx,
  input  logic [pcl_pkg::CHAR_W-1:0]   left_q,
  input  logic [pcl_pkg::CHAR_W-1:0]   right_q,
  output logic [pcl_pkg::CHAR_W-1:0]   q
);

  logic [pcl_pkg::CHAR_W-1:0] data_r;
  logic [pcl_pkg::CHAR_W-1:0] data_nxt;

  // An insert loads the new byte at index k and shifts the cells above it up; a remove closes the gap at index k.
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (my_idx == ctl.k) begin
        data_nxt = ctl.din;
      end else if (my_idx > ctl.k) begin
        data_nxt = left_q;
      end
    end else if (ctl.rem) begin
      if (my_idx >= ctl.k) begin
        data_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== rtl/pcl_chain.sv =====
// Row of byte cells with a read select for one rank.
module pcl_chain (
  input  logic                         clk,
  input  pcl_pkg::cell_ctl_t           ctl,
  input  logic [pcl_pkg::IDX_W-1:0]    rd_idx,
  output logic [pcl_pkg::CHAR_W-1:0]   rd_data
);

  logic [pcl_pkg::CHAR_W-1:0] q [pcl_pkg::CAPACITY];

  // Each cell sees its left and right neighbor; the ends see zero.
  for (genvar i = 0; i < pcl_pkg::CAPACITY; i++) begin : g_cell
    logic [pcl_pkg::CHAR_W-1:0] left_q;
    logic [pcl_pkg::CHAR_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = q[i-1];
    end

    if (i == pcl_pkg::CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = q[i+1];
    end

    pcl_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .my_idx  (pcl_pkg::IDX_W'(i)),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (q[i])
    );
  end

  // Single read select shared by rank reads and the dump walk.
  assign rd_data = q[rd_idx];

endmodule

// ===== rtl/positional_char_list.sv =====
// Positional character list: an ordered byte list kept in a shifting chain of
// cells and addressed by 1-based rank. Insert and remove shift or load every
// cell in parallel and a read selects one cell; the result of each is offered
// in the cycle after the item is taken. A dump walks the chain through a single
// read select, one byte per cycle while the output does not stall, with one
// step per stored byte after the step that takes the item.
// No new item is taken until the cycle in which the dump's last result
// transfers. Results go out through one output register, and an item is taken
// only when that register is empty or its result transfers in the same cycle,
// so a stalled result holds the input stalled as well.
module positional_char_list (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [pcl_pkg::POS_W-1:0]   in_position,
  input  logic [pcl_pkg::CHAR_W-1:0]  in_char_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [pcl_pkg::CHAR_W-1:0]  out_char_out,
  output logic                        out_last
);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t                       state_r;
  logic [pcl_pkg::CNT_W-1:0]    count_r;
  logic [pcl_pkg::IDX_W-1:0]    dump_idx_r;
  logic                         out_valid_r;
  pcl_pkg::status_t             out_status_r;
  logic [pcl_pkg::CHAR_W-1:0]   out_char_r;
  logic                         out_last_r;

  logic                         out_free;
  logic                         out_load;
  logic                         accept;
  logic [pcl_pkg::CMP_W-1:0]    pos_ext;
  logic [pcl_pkg::CMP_W-1:0]    cnt_ext;
  logic                         bad_pos;
  logic                         is_full;
  logic [pcl_pkg::CMP_W-1:0]    k_full;
  pcl_pkg::cell_ctl_t           ctl;
  logic [pcl_pkg::IDX_W-1:0]    rd_idx;
  logic [pcl_pkg::CHAR_W-1:0]   rd_data;
  logic                         dump_end;

  // Output register is free when empty or when its transfer happens now.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // A new result enters the output register for every taken item except a
  // dump of a non-empty list, and for every step of the dump walk.
  assign out_load = (state_r == S_IDLE) ?
                    (accept && !((in_action == pcl_pkg::ACT_DUMP) && (count_r != '0))) :
                    out_free;

  // Rank checks against the fill count.
  assign pos_ext = pcl_pkg::CMP_W'(in_position);
  assign cnt_ext = pcl_pkg::CMP_W'(count_r);
  assign is_full = (count_r == pcl_pkg::CNT_W'(pcl_pkg::CAPACITY));
  always_comb begin
    if (in_action == pcl_pkg::ACT_INSERT) begin
      bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext + pcl_pkg::CMP_W'(1));
    end else begin
      bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
    end
  end

  // Chain control: shift only on a valid, successful insert or remove.
  assign k_full  = pos_ext - pcl_pkg::CMP_W'(1);
  assign ctl.k   = k_full[pcl_pkg::IDX_W-1:0];
  assign ctl.din = in_char_in;
  assign ctl.ins = accept && (in_action == pcl_pkg::ACT_INSERT) && !bad_pos && !is_full;
  assign ctl.rem = accept && (in_action == pcl_pkg::ACT_REMOVE) && !bad_pos;

  assign rd_idx   = (state_r == S_DUMP) ? dump_idx_r : ctl.k;
  assign dump_end = (pcl_pkg::CNT_W'(dump_idx_r) + pcl_pkg::CNT_W'(1) == count_r);

  pcl_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // Sequencer, fill count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_action == pcl_pkg::ACT_DUMP) begin
              if (count_r == '0) begin
                out_status_r <= pcl_pkg::ST_EMPTY;
                out_char_r   <= '0;
                out_last_r   <= 1'b1;
              end else begin
                state_r    <= S_DUMP;
                dump_idx_r <= '0;
              end
            end else begin
              out_last_r  <= 1'b1;
              out_char_r  <= '0;
              if (bad_pos) begin
                out_status_r <= pcl_pkg::ST_BADPOS;
              end else if (in_action == pcl_pkg::ACT_INSERT && is_full) begin
                out_status_r <= pcl_pkg::ST_FULL;
              end else begin
                out_status_r <= pcl_pkg::ST_OK;
                if (in_action == pcl_pkg::ACT_READ) begin
                  out_char_r <= rd_data;
                end
                if (ctl.ins) begin
                  count_r <= count_r + pcl_pkg::CNT_W'(1);
                end else if (ctl.rem) begin
                  count_r <= count_r - pcl_pkg::CNT_W'(1);
                end
              end
            end
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_status_r <= pcl_pkg::ST_OK;
            out_char_r   <= rd_data;
            out_last_r   <= dump_end;
            if (dump_end) begin
              state_r <= S_IDLE;
            end else begin
              dump_idx_r <= dump_idx_r + pcl_pkg::IDX_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule

// ===== rtl/pcl_checker.sv =====
// Port-level checks for the positional character list, bound to the top level.
module pcl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  in_action,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_status,
  input logic [pcl_pkg::CHAR_W-1:0]  out_char_out,
  input logic                        out_last
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_char_out) && $stable(out_last))
    else $error("stalled result changed");

  // Every result that is not a plain ok ends its item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pcl_pkg::ST_OK) |-> out_last)
    else $error("error result without last");

  // Error results carry no byte.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pcl_pkg::ST_OK) |-> (out_char_out == '0))
    else $error("error result with nonzero byte");

  // Any item other than a dump has its result offered in the next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action != pcl_pkg::ACT_DUMP) |=> out_valid)
    else $error("single result not offered after its item");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind positional_char_list pcl_checker u_pcl_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the positional character list: a shadow list predicts every result.
module testbench;

  // One expected result of the list.
  typedef struct {
    pcl_pkg::status_t           status;
    logic [pcl_pkg::CHAR_W-1:0] char_out;
    logic                       last;
  } list_result_t;

  // Shadow copy of the ranked byte list and the queue of results it predicts.
  class rank_list_shadow;
    logic [pcl_pkg::CHAR_W-1:0] cells [pcl_pkg::CAPACITY];
    int                         fill;
    int                         errors;
    list_result_t               expected_results [$];

    function new();
      fill = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("MISMATCH at %0t ns: %s", $time, msg);
      end
    endtask

    function void push(pcl_pkg::status_t st, logic [pcl_pkg::CHAR_W-1:0] ch, logic lst);
      list_result_t r;
      r.status   = st;
      r.char_out = ch;
      r.last     = lst;
      expected_results.push_back(r);
    endfunction

    // Applies one accepted item to the shadow list and queues its results.
    function void note_item(pcl_pkg::action_t act, int rank, logic [pcl_pkg::CHAR_W-1:0] ch);
      int i;
      if (act == pcl_pkg::ACT_DUMP) begin
        if (fill == 0) begin
          push(pcl_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < fill; i++) push(pcl_pkg::ST_OK, cells[i], i == fill - 1);
        end
      end else if (act == pcl_pkg::ACT_INSERT) begin
        // The rank is checked before the store is checked for room.
        if (rank == 0 || rank > fill + 1) begin
          push(pcl_pkg::ST_BADPOS, '0, 1'b1);
        end else if (fill >= pcl_pkg::CAPACITY) begin
          push(pcl_pkg::ST_FULL, '0, 1'b1);
        end else begin
          for (i = fill; i > rank - 1; i--) cells[i] = cells[i - 1];
          cells[rank - 1] = ch;
          fill++;
          push(pcl_pkg::ST_OK, '0, 1'b1);
        end
      end else if (rank == 0 || rank > fill) begin
        push(pcl_pkg::ST_BADPOS, '0, 1'b1);
      end else if (act == pcl_pkg::ACT_READ) begin
        push(pcl_pkg::ST_OK, cells[rank - 1], 1'b1);
      end else begin
        for (i = rank - 1; i + 1 < fill; i++) cells[i] = cells[i + 1];
        fill--;
        push(pcl_pkg::ST_OK, '0, 1'b1);
      end
    endfunction

    // Compares one output transfer with the oldest expected result.
    task check_result(logic [1:0] st, logic [pcl_pkg::CHAR_W-1:0] ch, logic lst);
      list_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result status %0d char %02h last %0b", st, ch, lst));
        return;
      end
      want = expected_results.pop_front();
      if (st !== want.status) begin
        report($sformatf("status %0d, expected %0d", st, want.status));
      end
      if (ch !== want.char_out) begin
        report($sformatf("char_out %02h, expected %02h", ch, want.char_out));
      end
      if (lst !== want.last) begin
        report($sformatf("last %0b, expected %0b", lst, want.last));
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_action = pcl_pkg::ACT_INSERT;
  logic [pcl_pkg::POS_W-1:0]  in_position = '0;
  logic [pcl_pkg::CHAR_W-1:0] in_char_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_status;
  logic [pcl_pkg::CHAR_W-1:0] out_char_out;
  logic                       out_last;

  // While quiet is set, neither side idles.
  logic              quiet = 1'b0;
  rank_list_shadow   shadow;

  positional_char_list dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_position  (in_position),
    .in_char_in   (in_char_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check each transfer and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      shadow.check_result(out_status, out_char_out, out_last);
    end
    out_stall <= !quiet && ($urandom_range(99) < 24);
  end

  // Drives one item, with a random gap before it, and waits for its transfer.
  task automatic send_item(pcl_pkg::action_t act, int rank, logic [pcl_pkg::CHAR_W-1:0] ch);
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= rank[pcl_pkg::POS_W-1:0];
    in_char_in  <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_item(act, rank, ch);
  endtask

  // Mostly a valid rank in 1..hi, sometimes any position at all.
  function automatic int pick_rank(int hi);
    if (hi >= 1 && $urandom_range(99) < 85) return $urandom_range(hi, 1);
    return $urandom_range(63);
  endfunction

  initial begin
    int               n;
    int               sel;
    int               rank;
    int               cycles;
    bit               growing;
    pcl_pkg::action_t act;

    shadow = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: dump, and every action at a bad rank.
    send_item(pcl_pkg::ACT_DUMP, 0, 8'h00);
    send_item(pcl_pkg::ACT_READ, 1, 8'h00);
    send_item(pcl_pkg::ACT_REMOVE, 1, 8'h00);
    send_item(pcl_pkg::ACT_INSERT, 0, 8'h11);
    send_item(pcl_pkg::ACT_INSERT, 2, 8'h22);
    send_item(pcl_pkg::ACT_INSERT, 63, 8'h33);

    // Inserts at the end, the front and the middle, then reads and bad ranks.
    send_item(pcl_pkg::ACT_INSERT, 1, 8'h00);
    send_item(pcl_pkg::ACT_INSERT, 2, 8'hFF);
    send_item(pcl_pkg::ACT_INSERT, 1, 8'h5A);
    send_item(pcl_pkg::ACT_INSERT, 2, 8'hA5);
    send_item(pcl_pkg::ACT_READ, 1, 8'h00);
    send_item(pcl_pkg::ACT_READ, 4, 8'h00);
    send_item(pcl_pkg::ACT_READ, 5, 8'h00);
    send_item(pcl_pkg::ACT_READ, 0, 8'h00);
    send_item(pcl_pkg::ACT_REMOVE, 0, 8'h00);
    send_item(pcl_pkg::ACT_REMOVE, 5, 8'h00);
    send_item(pcl_pkg::ACT_DUMP, 0, 8'h00);

    // Removes from the middle, the front and the back, down to empty.
    send_item(pcl_pkg::ACT_REMOVE, 2, 8'h00);
    send_item(pcl_pkg::ACT_REMOVE, 1, 8'h00);
    send_item(pcl_pkg::ACT_REMOVE, 2, 8'h00);
    send_item(pcl_pkg::ACT_DUMP, 0, 8'h00);
    send_item(pcl_pkg::ACT_REMOVE, 1, 8'h00);

    // Fill the store, then try inserts while full and dump all of it.
    while (shadow.fill < pcl_pkg::CAPACITY) begin
      send_item(pcl_pkg::ACT_INSERT, $urandom_range(shadow.fill + 1, 1),
                8'($urandom_range(255)));
    end
    send_item(pcl_pkg::ACT_INSERT, pcl_pkg::CAPACITY + 1, 8'h77);
    send_item(pcl_pkg::ACT_INSERT, pcl_pkg::CAPACITY + 2, 8'h88);
    send_item(pcl_pkg::ACT_INSERT, 1, 8'h99);
    send_item(pcl_pkg::ACT_READ, pcl_pkg::CAPACITY, 8'h00);
    send_item(pcl_pkg::ACT_READ, pcl_pkg::CAPACITY + 1, 8'h00);
    send_item(pcl_pkg::ACT_READ, 63, 8'h00);
    send_item(pcl_pkg::ACT_DUMP, 0, 8'h00);

    // Random part: the fill level sweeps between empty and full and back.
    growing = 1'b0;
    for (n = 0; n < 310; n++) begin
      quiet = (n >= 150 && n < 230);
      if (n == 100) begin
        // Hold off until every outstanding result has arrived.
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.expected_results.size() != 0) @(posedge clk);
      end
      if (shadow.fill >= pcl_pkg::CAPACITY) begin
        growing = 1'b0;
      end else if (shadow.fill == 0) begin
        growing = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 6) begin
        act = pcl_pkg::ACT_DUMP;
      end else if (sel < 24) begin
        act = pcl_pkg::ACT_READ;
      end else if (sel < 62) begin
        act = growing ? pcl_pkg::ACT_INSERT : pcl_pkg::ACT_REMOVE;
      end else if (sel < 82) begin
        act = growing ? pcl_pkg::ACT_REMOVE : pcl_pkg::ACT_INSERT;
      end else begin
        act = pcl_pkg::action_t'($urandom_range(3));
      end
      if (sel >= 82) begin
        rank = $urandom_range(63);
      end else if (act == pcl_pkg::ACT_INSERT) begin
        rank = pick_rank(shadow.fill + 1);
      end else begin
        rank = pick_rank(shadow.fill);
      end
      send_item(act, rank, 8'($urandom_range(255)));
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow for a trailing dump.
    cycles = 0;
    while (shadow.expected_results.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (40) @(posedge clk);
    if (shadow.expected_results.size() != 0) begin
      shadow.report($sformatf("%0d expected results never arrived",
                              shadow.expected_results.size()));
    end
    if (shadow.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== positional_char_list.f =====
rtl/pcl_pkg.sv
rtl/pcl_cell.sv
rtl/pcl_chain.sv
rtl/positional_char_list.sv
rtl/pcl_checker.sv
test/testbench.sv
